// ----- rtl/core/nrfd_pkg.sv -----
// Shared types and constants of the nearest-replica forwarding decision block.
package nrfd_pkg;

   localparam int OP_W       = 2;
   localparam int NODE_W     = 8;
   localparam int IFACE_W    = 4;
   localparam int DIST_W     = 10;
   localparam int BEST_W     = 11;
   localparam int HOPS_W     = 8;
   localparam int RAND_W     = 16;
   localparam int MASK_W     = 16;
   localparam int OUTCOME_W  = 2;
   localparam int ICOUNT_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Interfaces that flooding may ever cover.
   localparam int NUM_IFACES = 16;

   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_HEADER = 2'd1;
   localparam logic [OP_W-1:0] OP_REPO   = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUT_NOT_INTEREST = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_DROPPED      = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_FLOODED      = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_NEAREST      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_HOP_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IFACE_COUNT = 2'd1;

   localparam logic [HOPS_W-1:0]   HOP_LIMIT_RESET   = 8'd8;
   localparam logic [ICOUNT_W-1:0] IFACE_COUNT_RESET = 5'd16;
   localparam logic [BEST_W-1:0]   NO_BEST           = '1;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [NODE_W-1:0]  node_id;
      logic [IFACE_W-1:0] entry_iface;
      logic [DIST_W-1:0]  entry_distance;
      logic               is_interest;
      logic               found;
      logic [HOPS_W-1:0]  hops;
      logic [IFACE_W-1:0] arrival_iface;
      logic               last;
      logic [RAND_W-1:0]  random_value;
   } req_word_type;

   typedef struct packed {
      logic [MASK_W-1:0]    iface_mask;
      logic [NODE_W-1:0]    chosen_node;
      logic [OUTCOME_W-1:0] outcome;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
   } csr_word_type;

endpackage

// ----- rtl/core/nrfd_req_if.sv -----
// Request channel: valid/ready handshake carrying one request word.
interface nrfd_req_if;
   import nrfd_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/nrfd_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one decision word.
interface nrfd_rsp_if;
   import nrfd_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/nrfd_csr_if.sv -----
// Register write channel: valid/ready handshake carrying index and write data.
interface nrfd_csr_if;
   import nrfd_pkg::*;

   logic         valid;
   logic         ready;
   csr_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/nrfd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module nrfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic                                 re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/nearest_replica_forwarding_decision.sv -----
// Top level of the nearest-replica forwarding decision engine.
//
// Usage:
//   req_chan carries one request word per handshake: a table write, an
//   interest header, or a repository node. rsp_chan returns at most one
//   decision word per request: interface mask, chosen node and outcome.
//   csr_chan writes hop_limit (index 0) and iface_count (index 1); it is
//   always ready and should be used only while the block is idle.
// Sequencing:
//   A new request word is taken only while the block is idle. A table
//   write, a found header, an unused code and a repository word outside a
//   collection leave it idle. A header that answers goes to the output
//   load, which places its decision word in the output register. A
//   repository word that is not the last goes through a table read, then
//   a compare. The last one goes through acceptance with the table read,
//   compare, a bit-serial remainder unit that reduces random_value by the
//   tie count, a tie-list read, a table read for the chosen node's
//   interface, the mask build and the output load. The forwarding table
//   and the tie list each sit in a RAM with one write and one read port
//   and registered read data; items go through those ports in turn.
// Reset:
//   Synchronous reset restores hop_limit 8 and iface_count 16 and ends any
//   collection. Table and tie-list contents are not cleared.
// Stall:
//   The decision word waits in an output register while rsp_chan.ready is
//   low; words that answer nothing are still taken meanwhile, and the next
//   decision word holds the input until the output register frees up.
module nearest_replica_forwarding_decision #(
   parameter int NUM_NODES = 256,
   parameter int MAX_TIES  = 16
) (
   input logic        clock,
   input logic        reset,
   nrfd_req_if.sink   req_chan,
   nrfd_rsp_if.source rsp_chan,
   nrfd_csr_if.sink   csr_chan
);
   import nrfd_pkg::*;

   localparam int NODE_AW = NUM_NODES > 1 ? $clog2(NUM_NODES) : 1;
   localparam int TIE_AW  = MAX_TIES > 1 ? $clog2(MAX_TIES) : 1;
   localparam int CNT_W   = $clog2(MAX_TIES + 1);
   localparam int STEP_W  = $clog2(RAND_W);
   localparam int ENTRY_W = IFACE_W + DIST_W;
   localparam int NODE_SPAN = 2 ** NODE_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CMP   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_TRD   = 3'd3;
   localparam logic [2:0] ST_TNODE = 3'd4;
   localparam logic [2:0] ST_TIF   = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   // Control registers
   logic [2:0]          state_ff, state_in;
   logic [HOPS_W-1:0]   hop_limit_ff, hop_limit_in;
   logic [ICOUNT_W-1:0] iface_count_ff, iface_count_in;
   logic                collecting_ff, collecting_in;
   logic [BEST_W-1:0]   best_ff, best_in;
   logic [CNT_W-1:0]    tie_count_ff, tie_count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [NODE_AW-1:0]  node_ff, node_in;
   logic                last_ff, last_in;
   logic [RAND_W-1:0]   rand_ff, rand_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NODE_AW-1:0]  chosen_ff, chosen_in;
   rsp_word_type        res_ff, res_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   // RAM ports
   logic               tab_we, tab_re;
   logic [NODE_AW-1:0] tab_raddr;
   logic [ENTRY_W-1:0] tab_rdata;
   logic               tie_we, tie_re;
   logic [TIE_AW-1:0]  tie_waddr, tie_raddr;
   logic [NODE_AW-1:0] tie_rdata;

   logic               req_fire, csr_fire, out_free;
   logic [NODE_AW-1:0] req_node;
   logic [NODE_AW-1:0] node_mod [NODE_SPAN];
   logic [ICOUNT_W-1:0] used_ifaces;
   logic [MASK_W-1:0]  flood_mask;
   logic [BEST_W-1:0]  cand_dist;
   logic [CNT_W:0]     trial;

   // Node index reduced by the table size; a constant lookup on 8-bit ids.
   for (genvar g = 0; g < NODE_SPAN; g++) begin : g_node_mod
      assign node_mod[g] = NODE_AW'(g % NUM_NODES);
   end

   assign req_node = node_mod[req_chan.data.node_id];

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   // Flood on used interfaces except the arrival one.
   assign used_ifaces = (iface_count_ff > ICOUNT_W'(NUM_IFACES)) ?
                        ICOUNT_W'(NUM_IFACES) : iface_count_ff;

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         flood_mask[i] = (ICOUNT_W'(i) < used_ifaces) &&
                         (IFACE_W'(i) != req_chan.data.arrival_iface);
      end
   end

   assign cand_dist = {1'b0, tab_rdata[DIST_W-1:0]};
   assign trial     = {rem_ff, rand_ff[RAND_W-1]};

   always_comb begin
      state_in       = state_ff;
      hop_limit_in   = hop_limit_ff;
      iface_count_in = iface_count_ff;
      collecting_in  = collecting_ff;
      best_in        = best_ff;
      tie_count_in   = tie_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      node_in        = node_ff;
      last_in        = last_ff;
      rand_in        = rand_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      chosen_in      = chosen_ff;
      res_in         = res_ff;
      rsp_word_in    = rsp_word_ff;
      tab_we         = 1'b0;
      tab_re         = 1'b0;
      tab_raddr      = req_node;
      tie_we         = 1'b0;
      tie_waddr      = '0;
      tie_re         = 1'b0;
      tie_raddr      = rem_ff[TIE_AW-1:0];

      if (csr_fire) begin
         case (csr_chan.data.index)
            CSR_HOP_LIMIT:   hop_limit_in   = csr_chan.data.value[HOPS_W-1:0];
            CSR_IFACE_COUNT: iface_count_in = csr_chan.data.value[ICOUNT_W-1:0];
            default: ;
         endcase
      end

      // Drop the decision word once taken.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               node_in = req_node;
               last_in = req_chan.data.last;
               rand_in = req_chan.data.random_value;
               case (req_chan.data.operation)
                  OP_WRITE: begin
                     tab_we = 1'b1;
                  end
                  OP_HEADER: begin
                     // Any header abandons an open collection.
                     collecting_in = 1'b0;
                     res_in        = '0;
                     if (!req_chan.data.is_interest) begin
                        res_in.outcome = OUT_NOT_INTEREST;
                        state_in       = ST_EMIT;
                     end else if (req_chan.data.found) begin
                        best_in       = NO_BEST;
                        tie_count_in  = '0;
                        collecting_in = 1'b1;
                     end else if (req_chan.data.hops >= hop_limit_ff) begin
                        res_in.outcome = OUT_DROPPED;
                        state_in       = ST_EMIT;
                     end else begin
                        res_in.iface_mask = flood_mask;
                        res_in.outcome    = OUT_FLOODED;
                        state_in          = ST_EMIT;
                     end
                  end
                  OP_REPO: begin
                     if (collecting_ff) begin
                        tab_re   = 1'b1;
                        state_in = ST_CMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CMP: begin
            if (cand_dist < best_ff) begin
               // Nearer node restarts the tie list.
               best_in      = cand_dist;
               tie_we       = 1'b1;
               tie_waddr    = '0;
               tie_count_in = CNT_W'(1);
            end else if (cand_dist == best_ff && tie_count_ff < CNT_W'(MAX_TIES)) begin
               tie_we       = 1'b1;
               tie_waddr    = tie_count_ff[TIE_AW-1:0];
               tie_count_in = tie_count_ff + CNT_W'(1);
            end
            if (last_ff) begin
               collecting_in = 1'b0;
               rem_in        = '0;
               step_in       = '0;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // One restoring remainder step per cycle, MSB first.
            if (trial >= {1'b0, tie_count_ff}) begin
               rem_in = CNT_W'(trial - {1'b0, tie_count_ff});
            end else begin
               rem_in = trial[CNT_W-1:0];
            end
            rand_in = {rand_ff[RAND_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RAND_W - 1)) begin
               state_in = ST_TRD;
            end
         end
         ST_TRD: begin
            tie_re   = 1'b1;
            state_in = ST_TNODE;
         end
         ST_TNODE: begin
            chosen_in = tie_rdata;
            tab_re    = 1'b1;
            tab_raddr = tie_rdata;
            state_in  = ST_TIF;
         end
         ST_TIF: begin
            res_in.iface_mask  = MASK_W'(1) << tab_rdata[DIST_W +: IFACE_W];
            res_in.chosen_node = NODE_W'(chosen_ff);
            res_in.outcome     = OUT_NEAREST;
            state_in           = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hop_limit_ff   <= HOP_LIMIT_RESET;
         iface_count_ff <= IFACE_COUNT_RESET;
         collecting_ff  <= 1'b0;
         best_ff        <= NO_BEST;
         tie_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hop_limit_ff   <= hop_limit_in;
         iface_count_ff <= iface_count_in;
         collecting_ff  <= collecting_in;
         best_ff        <= best_in;
         tie_count_ff   <= tie_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      last_ff     <= last_in;
      rand_ff     <= rand_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      chosen_ff   <= chosen_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Forwarding table: {interface, distance} per node.
   nrfd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_NODES)
   ) u_table_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (req_node),
      .wdata ({req_chan.data.entry_iface, req_chan.data.entry_distance}),
      .re    (tab_re),
      .raddr (tab_raddr),
      .rdata (tab_rdata)
   );

   // Tie list of equally near repository nodes.
   nrfd_ram #(
      .WIDTH (NODE_AW),
      .DEPTH (MAX_TIES)
   ) u_tie_ram (
      .clock (clock),
      .we    (tie_we),
      .waddr (tie_waddr),
      .wdata (node_ff),
      .re    (tie_re),
      .raddr (tie_raddr),
      .rdata (tie_rdata)
   );

   a_tie_count_cap: assert property (@(posedge clock) disable iff (reset)
      tie_count_ff <= CNT_W'(MAX_TIES))
      else $error("tie count above list capacity");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (tie_count_ff != '0))
      else $error("tie choice with empty tie list");

   a_header_ends_collect: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.data.operation == OP_HEADER && !req_chan.data.found)
      |=> !collecting_ff)
      else $error("collection survived a header");

   a_emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("decision word not loaded");

endmodule
